// ===== sv/bb3_pkg.sv =====
// Shared types, constants and helper functions for the 3x3 box blur stream.
package bb3_pkg;

  // Pixel and frame geometry
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int MIN_DIM    = 3;

  // Sum widths: one column of three pixels, and the full nine-pixel window
  localparam int COL_SUM_W  = PIX_W + 2;
  localparam int WIN_SUM_W  = PIX_W + 4;

  // Division by nine as a multiply by a rounded-up reciprocal and a shift.
  // The error stays below one ninth for every window sum up to 9 * 255.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_9     = (1 << RECIP_SHIFT) / 9 + 1;
  localparam int RECIP_W     = $clog2(RECIP_9 + 1);
  localparam int PROD_W      = WIN_SUM_W + RECIP_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // One column of the 3x3 window, oldest row on top
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // Last column index for a width register, saturated into the legal range.
  function automatic logic [XW-1:0] width_last(logic [CFG_W-1:0] v);
    logic [XW-1:0] r;
    if (32'(v) < MIN_DIM) begin
      r = XW'(MIN_DIM - 1);
    end else if (32'(v) > MAX_WIDTH) begin
      r = XW'(MAX_WIDTH - 1);
    end else begin
      r = XW'(v - CFG_W'(1));
    end
    return r;
  endfunction

  // Last row index for a height register, saturated into the legal range.
  function automatic logic [YW-1:0] height_last(logic [CFG_W-1:0] v);
    logic [YW-1:0] r;
    if (32'(v) < MIN_DIM) begin
      r = YW'(MIN_DIM - 1);
    end else if (32'(v) > MAX_HEIGHT) begin
      r = YW'(MAX_HEIGHT - 1);
    end else begin
      r = YW'(v - CFG_W'(1));
    end
    return r;
  endfunction

endpackage

// ===== sv/bb3_line_mem.sv =====
// Dual line store: each entry holds the pixel two rows up and one row up.
module bb3_line_mem (
  input  logic                         clk,
  input  logic                         we,
  input  logic [bb3_pkg::XW-1:0]       waddr,
  input  logic [2*bb3_pkg::PIX_W-1:0]  wdata,
  input  logic                         re,
  input  logic [bb3_pkg::XW-1:0]       raddr,
  output logic [2*bb3_pkg::PIX_W-1:0]  rdata
);
  import bb3_pkg::*;

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bb3_cell.sv =====
// One window cell: holds a column of three pixels and its sum, passes it on when shifted.
module bb3_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            shift,
  input  bb3_pkg::col_t                   col_in,
  output bb3_pkg::col_t                   col_out,
  output logic [bb3_pkg::COL_SUM_W-1:0]   col_sum
);
  import bb3_pkg::*;

  logic [COL_SUM_W-1:0] sum_next;

  // Column sum is formed on load so the window adder sees it ready
  assign sum_next = COL_SUM_W'(col_in.top) + COL_SUM_W'(col_in.mid) +
                    COL_SUM_W'(col_in.bot);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
      col_sum <= '0;
    end else if (shift) begin
      col_out <= col_in;
      col_sum <= sum_next;
    end
  end

endmodule

// ===== sv/box_blur_3x3_stream.sv =====
// Top level of the streaming 3x3 box blur (mean) filter for 8-bit grayscale frames.
//
// Usage:
//   Pixels enter on the s_ channel in raster order, one item per pixel, for a
//   frame of image_width by image_height pixels (each saturated into 3..1024).
//   For every interior pixel one item leaves on the m_ channel: the floor of
//   the 3x3 neighborhood sum divided by nine, with m_tlast set on the last
//   interior result of the frame. Border pixels give no item.
//   The result for pixel (r-1, c-1) is produced by the input item at (r, c);
//   with no stall it passes the line store read (stage 1), the window sum
//   (stage 2) and the divide-by-nine multiply into the output register.
//   Unstalled throughput is one item per cycle, set by one read and one write of the
//   line store per item and the two-cell column chain that shifts once per item.
//   When the receiver stalls, the pipeline fills (three items deep) and then
//   s_tready drops; nothing is lost. Once all three stages hold interior
//   items, s_tready follows m_tready combinationally through the ready chain.
//   Reset clears the row and column counters, the pipeline and sets both
//   registers to 512. The line stores are not cleared; no clearing pass runs.
//   A width or height write restarts the frame at row 0, column 0; write only
//   while the block is idle.
module box_blur_3x3_stream (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]       cfg_data,
  // Pixel input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] pixel
  // Blurred output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] blurred
  output logic                            m_tlast    // frame_last
);
  import bb3_pkg::*;

  // Configuration registers and frame position
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [XW-1:0]    col_cnt;
  logic [YW-1:0]    row_cnt;
  logic [XW-1:0]    col_last;
  logic [YW-1:0]    row_last;

  // Pipeline stage 1: pixel plus line store read
  logic              v1;
  logic [PIX_W-1:0]  bot1;
  logic [XW-1:0]     x1;
  logic              emit1;
  logic              last1;
  logic [2*PIX_W-1:0] rd_data;

  // Pipeline stage 2: window sum
  logic                 v2;
  logic [WIN_SUM_W-1:0] sum2;
  logic                 last2;

  // Output register
  logic              ov;
  logic [PIX_W-1:0]  odata;
  logic              olast;

  // Handshake and window signals
  logic               in_fire;
  logic               ready3;
  logic               ready2;
  logic               leave1;
  logic               cfg_hit;
  col_t               cur_col;
  col_t               col_a;
  col_t               col_b;
  logic [COL_SUM_W-1:0] sum_a;
  logic [COL_SUM_W-1:0] sum_b;
  logic [COL_SUM_W-1:0] cur_sum;
  logic [WIN_SUM_W-1:0] win_sum;
  logic [PROD_W-1:0]    prod;

  assign col_last = width_last(image_width);
  assign row_last = height_last(image_height);

  // Ready chain from the output register back to the input
  assign ready3   = !ov || m_tready;
  assign ready2   = !v2 || ready3;
  assign leave1   = v1 && (!emit1 || ready2);
  assign s_tready = !v1 || !emit1 || ready2;
  assign in_fire  = s_tvalid && s_tready;

  assign cfg_hit = cfg_we &&
                   (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(512);
      image_height <= CFG_W'(512);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Raster position of the next input item
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_fire) begin
      if (col_cnt == col_last) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == row_last) ? '0 : row_cnt + YW'(1);
      end else begin
        col_cnt <= col_cnt + XW'(1);
      end
    end
  end

  // Line stores: read at accept, write the shifted pair when the item leaves stage 1
  bb3_line_mem u_line_mem (
    .clk   (clk),
    .we    (leave1),
    .waddr (x1),
    .wdata ({rd_data[PIX_W-1:0], bot1}),
    .re    (in_fire),
    .raddr (col_cnt),
    .rdata (rd_data)
  );

  // Stage 1 control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_fire) begin
      v1 <= 1'b1;
    end else if (leave1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bot1  <= s_tdata;
      x1    <= col_cnt;
      emit1 <= (32'(col_cnt) >= 2) && (32'(row_cnt) >= 2);
      last1 <= (col_cnt == col_last) && (row_cnt == row_last);
    end
  end

  // Current column and the chain of two previous columns
  assign cur_col.top = rd_data[2*PIX_W-1:PIX_W];
  assign cur_col.mid = rd_data[PIX_W-1:0];
  assign cur_col.bot = bot1;

  bb3_cell u_cell_a (
    .clk     (clk),
    .rst     (rst),
    .shift   (leave1),
    .col_in  (cur_col),
    .col_out (col_a),
    .col_sum (sum_a)
  );

  bb3_cell u_cell_b (
    .clk     (clk),
    .rst     (rst),
    .shift   (leave1),
    .col_in  (col_a),
    .col_out (col_b),
    .col_sum (sum_b)
  );

  // Window sum over the three columns
  assign cur_sum = COL_SUM_W'(cur_col.top) + COL_SUM_W'(cur_col.mid) +
                   COL_SUM_W'(cur_col.bot);
  assign win_sum = WIN_SUM_W'(cur_sum) + WIN_SUM_W'(sum_a) + WIN_SUM_W'(sum_b);

  // Stage 2: registered window sum for interior pixels only
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= leave1 && emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && leave1 && emit1) begin
      sum2  <= win_sum;
      last2 <= last1;
    end
  end

  // Divide by nine through the reciprocal multiply
  assign prod = PROD_W'(sum2) * PROD_W'(RECIP_9);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ready3) begin
      ov <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      odata <= prod[RECIP_SHIFT +: PIX_W];
      olast <= last2;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = odata;
  assign m_tlast  = olast;

endmodule

// ===== sv/bb3_checker.sv =====
// Port-level checker for the box blur stream, bound to the top level.
module bb3_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value and frame mark
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Reset empties the pipeline: no result can appear before a new item passes stages 1 and 2
  assert property (@(posedge clk)
    rst |=> !m_tvalid ##1 !m_tvalid)
    else $error("result appeared too soon after reset");

  // With the output side empty, the pipeline always has room for an item
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind box_blur_3x3_stream bb3_checker u_bb3_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
